[hw/rtl/i2r_pkg.sv]
// ----------------------------------------------------------------------------
// i2r_pkg: shared types, constants and functions for the Roman numeral encoder
// Holds the symbol codes, the queue entry format and the small digit tables
// used by the decimal split and the symbol sequencer.
// ----------------------------------------------------------------------------
package i2r_pkg;

	localparam int VALUE_W     = 12;
	localparam int SYM_W       = 3;
	localparam int DIGITS      = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int MAX_VALUE   = 3999;
	localparam int WEIGHT_W    = 14;

	localparam int W_THOUSAND = 1000;
	localparam int W_HUNDRED  = 100;
	localparam int W_TEN      = 10;
	localparam int W_UNIT     = 1;

	typedef enum logic [SYM_W-1:0] {
		SYM_I = 3'd0,
		SYM_V = 3'd1,
		SYM_X = 3'd2,
		SYM_L = 3'd3,
		SYM_C = 3'd4,
		SYM_D = 3'd5,
		SYM_M = 3'd6
	} sym_t;

	// One queued number: decimal digits, units in digit[0].
	typedef struct packed {
		logic [DIGITS-1:0][3:0] digit;
		logic                   range_error;
	} i2r_entry_t;

	typedef struct packed {
		logic       found;
		logic [1:0] pos;
	} i2r_pos_t;

	// k times the decimal weight of position pos; k is an elaboration constant
	function automatic logic [WEIGHT_W-1:0] step_weight(input logic [1:0] pos, input int k);
		logic [WEIGHT_W-1:0] w;
		case (pos)
			2'd3:    w = WEIGHT_W'(k * W_THOUSAND);
			2'd2:    w = WEIGHT_W'(k * W_HUNDRED);
			2'd1:    w = WEIGHT_W'(k * W_TEN);
			default: w = WEIGHT_W'(k * W_UNIT);
		endcase
		return w;
	endfunction

	// Number of symbols a decimal digit expands to
	function automatic logic [2:0] digit_len(input logic [3:0] d);
		logic [2:0] n;
		case (d)
			4'd1:    n = 3'd1;
			4'd2:    n = 3'd2;
			4'd3:    n = 3'd3;
			4'd4:    n = 3'd2;
			4'd5:    n = 3'd1;
			4'd6:    n = 3'd2;
			4'd7:    n = 3'd3;
			4'd8:    n = 3'd4;
			4'd9:    n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// Symbol at position step within the run for digit d at decimal position pos
	function automatic sym_t digit_sym(input logic [3:0] d, input logic [1:0] step,
			input logic [1:0] pos);
		logic [SYM_W-1:0] one;
		logic [SYM_W-1:0] five;
		logic [SYM_W-1:0] ten;
		sym_t             s;
		one  = {pos, 1'b0};
		five = {pos, 1'b1};
		ten  = one + 3'd2;
		case (d)
			4'd4:    s = sym_t'((step == 2'd0) ? one : five);
			4'd9:    s = sym_t'((step == 2'd0) ? one : ten);
			default: s = sym_t'((d >= 4'd5 && step == 2'd0) ? five : one);
		endcase
		return s;
	endfunction

	// Highest position below limit that holds a nonzero digit
	function automatic i2r_pos_t next_pos(input logic [DIGITS-1:0][3:0] digit,
			input logic [2:0] limit);
		i2r_pos_t r;
		r = '0;
		for (int i = 0; i < DIGITS; i++) begin
			if (3'(i) < limit && digit[i] != 4'd0) begin
				r.found = 1'b1;
				r.pos   = 2'(i);
			end
		end
		return r;
	endfunction

endpackage

[hw/rtl/i2r_front.sv]
// ----------------------------------------------------------------------------
// i2r_front: input stage of the Roman numeral encoder
// Accepts a binary value, flags out-of-range values and splits valid ones
// into four decimal digits, one position per cycle, then queues the result.
// ----------------------------------------------------------------------------
module i2r_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [15:0]                   s_axis_tdata,   // [11:0] value
	output logic                          push_valid,
	input  logic                          push_ready,
	output i2r_pkg::i2r_entry_t           push_data
);
	import i2r_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CONV = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	front_state_t        state_q;
	logic [VALUE_W-1:0]  rem_q;
	logic [1:0]          pos_q;
	i2r_entry_t          entry_q;
	logic [VALUE_W-1:0]  value;
	logic                bad_value;
	logic [3:0]          dig;
	logic [WEIGHT_W-1:0] sub;
	logic [WEIGHT_W-1:0] w;

	assign value         = s_axis_tdata[VALUE_W-1:0];
	assign bad_value     = (value == '0) || (value > VALUE_W'(MAX_VALUE));
	assign s_axis_tready = (state_q == F_IDLE);
	assign push_valid    = (state_q == F_PUSH);
	assign push_data     = entry_q;

	// largest k with k * weight not above the remainder
	always_comb begin
		dig = '0;
		sub = '0;
		w   = '0;
		for (int k = 1; k <= 9; k++) begin
			w = step_weight(pos_q, k);
			if ({{(WEIGHT_W-VALUE_W){1'b0}}, rem_q} >= w) begin
				dig = 4'(k);
				sub = w;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= bad_value ? F_PUSH : F_CONV;
					end
				end
				F_CONV: begin
					if (pos_q == 2'd0) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && s_axis_tvalid) begin
			rem_q               <= value;
			pos_q               <= 2'd3;
			entry_q.digit       <= '0;
			entry_q.range_error <= bad_value;
		end else if (state_q == F_CONV) begin
			entry_q.digit[pos_q] <= dig;
			rem_q                <= rem_q - sub[VALUE_W-1:0];
			pos_q                <= pos_q - 2'd1;
		end
	end

endmodule

[hw/rtl/i2r_queue.sv]
// ----------------------------------------------------------------------------
// i2r_queue: short queue of split numbers between front and back
// Circular buffer with an occupancy count; lets each side stall on its own.
// ----------------------------------------------------------------------------
module i2r_queue #(
	parameter int DEPTH = i2r_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  i2r_pkg::i2r_entry_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output i2r_pkg::i2r_entry_t pop_data
);
	import i2r_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	i2r_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[hw/rtl/i2r_back.sv]
// ----------------------------------------------------------------------------
// i2r_back: symbol sequencer of the Roman numeral encoder
// Takes one split number from the queue and walks its digits, skipping zero
// digits, emitting one symbol per cycle into an output register unless it is held.
// ----------------------------------------------------------------------------
module i2r_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  i2r_pkg::i2r_entry_t pop_data,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [7:0]          m_axis_tdata,   // [2:0] symbol
	output logic                m_axis_tlast,
	output logic                m_axis_tuser    // [0] range_error
);
	import i2r_pkg::*;

	logic             busy_q;
	i2r_entry_t       ent_q;
	logic [1:0]       pos_q;
	logic [1:0]       step_q;
	logic             out_valid_q;
	sym_t             symbol_q;
	logic             last_q;
	logic             error_q;

	logic [3:0]       cur_d;
	logic             digit_end;
	i2r_pos_t         nxt;
	i2r_pos_t         first;
	logic             last;
	sym_t             symbol;
	logic             gen;

	assign cur_d     = ent_q.digit[pos_q];
	assign digit_end = ({1'b0, step_q} == digit_len(cur_d) - 3'd1);
	assign nxt       = next_pos(ent_q.digit, {1'b0, pos_q});
	assign first     = next_pos(pop_data.digit, 3'd4);
	assign last      = ent_q.range_error || (digit_end && !nxt.found);
	assign symbol    = ent_q.range_error ? SYM_I : digit_sym(cur_d, step_q, pos_q);
	assign gen       = busy_q && (!out_valid_q || m_axis_tready);
	assign pop_ready = !busy_q;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(8-SYM_W){1'b0}}, symbol_q};
	assign m_axis_tlast  = last_q;
	assign m_axis_tuser  = error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy_q && pop_valid) begin
				busy_q <= 1'b1;
			end else if (gen && last) begin
				busy_q <= 1'b0;
			end
			if (gen) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && pop_valid) begin
			ent_q  <= pop_data;
			pos_q  <= first.pos;
			step_q <= '0;
		end else if (gen) begin
			// advance within the digit, or hop to the next nonzero one
			if (digit_end) begin
				pos_q  <= nxt.pos;
				step_q <= '0;
			end else begin
				step_q <= step_q + 2'd1;
			end
		end
		if (gen) begin
			symbol_q <= symbol;
			last_q   <= last;
			error_q  <= ent_q.range_error;
		end
	end

endmodule

[hw/rtl/integer_to_roman_encoder_top.sv]
// ----------------------------------------------------------------------------
// integer_to_roman_encoder_top: binary integer to Roman numeral encoder
// Converts each request into its Roman numeral, one symbol per result.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per number: tdata[11:0] is the value.
//   m_axis returns the numeral most significant symbol first, tdata[2:0]
//   holding the symbol (I V X L C D M as 0 to 6); tlast marks the final
//   symbol of a number. A value of zero or above 3999 returns a single
//   result with tuser (range error) and tlast high and symbol I.
//   From the accepting edge of a request, the front splits the digits from
//   thousands down to units, pushes the entry into the queue, the sequencer
//   loads it, and its first symbol goes into the output register that drives
//   m_axis_tvalid; an out-of-range value skips the split. The sequencer
//   emits one symbol per cycle unless the receiver stalls; a number has
//   1 to 15 symbols, and the next entry is loaded after its last one. The
//   input side takes a new request only once the last one is pushed.
//   A two-entry queue lets the digit split run ahead while symbols drain.
//   When the receiver stalls, the output register holds its symbol and
//   the queue fills, after which s_axis_tready drops.
//   Reset clears the queue and all handshake state; no result is pending.
// ----------------------------------------------------------------------------
module integer_to_roman_encoder_top #(
	parameter int QUEUE_DEPTH = i2r_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [11:0] value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [2:0] symbol
	output logic        m_axis_tlast,
	output logic        m_axis_tuser    // [0] range_error
);
	import i2r_pkg::*;

	logic       push_valid;
	logic       push_ready;
	i2r_entry_t push_data;
	logic       pop_valid;
	logic       pop_ready;
	i2r_entry_t pop_data;

	i2r_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	i2r_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	i2r_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

[tb/integer_to_roman_encoder_top_tb.sv]
// ----------------------------------------------------------------------------
// integer_to_roman_encoder_top_tb: self-checking bench for the Roman encoder
// Drives binary values into s_axis and checks every symbol on m_axis. A
// local predictor expands each accepted request into its expected symbol
// run. The run starts with directed values, then covers a long receiver
// hold-off, a stretch without idling and a long random section.
// ----------------------------------------------------------------------------
module integer_to_roman_encoder_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import i2r_pkg::*;

	localparam int RESET_CYCLES   = 8;
	localparam int RX_LONG_HOLD   = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 24;
	localparam int HOLD_ITEMS     = 20;
	localparam int FREE_ITEMS     = 30;
	localparam int RANDOM_ITEMS   = 95;
	localparam int DIRECTED_ITEMS = 25;

	typedef struct {
		sym_t symbol;
		bit   last;
		bit   range_error;
	} numeral_sym_t;

	class numeral_scoreboard;
		numeral_sym_t pending_q[$];
		int           errors;
		int           requests_seen;
		int           symbols_seen;
		int           range_errors_seen;

		function new();
			errors            = 0;
			requests_seen     = 0;
			symbols_seen      = 0;
			range_errors_seen = 0;
		endfunction

		function sym_t one_sym(int pos);
			case (pos)
				3:       return SYM_M;
				2:       return SYM_C;
				1:       return SYM_X;
				default: return SYM_I;
			endcase
		endfunction

		function sym_t five_sym(int pos);
			case (pos)
				2:       return SYM_D;
				1:       return SYM_L;
				default: return SYM_V;
			endcase
		endfunction

		function void add_expected(numeral_sym_t s);
			pending_q = {pending_q, s};
		endfunction

		// Expand one accepted request into the symbols it must produce
		function void note_request(logic [VALUE_W-1:0] value);
			numeral_sym_t s;
			int           weight[4];
			int           d;
			weight = '{1, 10, 100, 1000};
			requests_seen++;
			s.last        = 1'b0;
			s.range_error = 1'b0;
			if (value == 0 || value > MAX_VALUE) begin
				s.symbol      = SYM_I;
				s.last        = 1'b1;
				s.range_error = 1'b1;
				range_errors_seen++;
				add_expected(s);
				return;
			end
			for (int pos = DIGITS - 1; pos >= 0; pos--) begin
				d = (int'(value) / weight[pos]) % 10;
				if (d == 9) begin
					s.symbol = one_sym(pos);
					add_expected(s);
					s.symbol = one_sym(pos + 1);
					add_expected(s);
				end else if (d == 4) begin
					s.symbol = one_sym(pos);
					add_expected(s);
					s.symbol = five_sym(pos);
					add_expected(s);
				end else begin
					if (d >= 5) begin
						s.symbol = five_sym(pos);
						add_expected(s);
						d -= 5;
					end
					for (int i = 0; i < d; i++) begin
						s.symbol = one_sym(pos);
						add_expected(s);
					end
				end
			end
			pending_q[pending_q.size() - 1].last = 1'b1;
		endfunction

		function void check_symbol(logic [7:0] tdata, logic tlast, logic tuser);
			numeral_sym_t want;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected symbol %0d last %0b error %0b", $time,
					tdata[SYM_W-1:0], tlast, tuser);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			symbols_seen++;
			if (tdata[SYM_W-1:0] !== want.symbol) begin
				$display("%0t: symbol mismatch: expected %0d actual %0d", $time,
					want.symbol, tdata[SYM_W-1:0]);
				errors++;
			end
			if (tlast !== want.last) begin
				$display("%0t: tlast mismatch: expected %0b actual %0b", $time,
					want.last, tlast);
				errors++;
			end
			if (tuser !== want.range_error) begin
				$display("%0t: range error mismatch: expected %0b actual %0b", $time,
					want.range_error, tuser);
				errors++;
			end
		endfunction
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;  // [11:0] value
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // [2:0] symbol
	logic        m_axis_tlast;
	logic        m_axis_tuser;        // [0] range_error

	numeral_scoreboard sb = new();

	bit no_idle;
	bit tx_eager;
	int hold_asked;

	integer_to_roman_encoder_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return VALUE_W'($urandom_range(MAX_VALUE + 1, 4095));
		else if (r < 8)
			return '0;
		else if (r < 40)
			// build from digits so that 4s, 8s and 9s turn up often
			return VALUE_W'($urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100
				+ $urandom_range(0, 9) * 10 + $urandom_range(1, 9));
		else
			return VALUE_W'($urandom_range(1, MAX_VALUE));
	endfunction

	task automatic send_request(input logic [VALUE_W-1:0] value);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= 16'(value);
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_request(value);
		gap = (no_idle || tx_eager) ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the sender until every expected symbol has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: check accepted symbols and pick the next tready
	initial begin
		int stall;
		int r;
		int hold_seen;
		stall     = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid === 1'b1 && m_axis_tready)
				sb.check_symbol(m_axis_tdata, m_axis_tlast, m_axis_tuser);
			if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				stall     = RX_LONG_HOLD;
				m_axis_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else if (no_idle) begin
				m_axis_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					m_axis_tready <= 1'b1;
				end else begin
					stall = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
					m_axis_tready <= 1'b0;
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves on either side for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		logic [VALUE_W-1:0] directed[DIRECTED_ITEMS];
		directed = '{1, 3999, 0, 4000, 4095, 3888, 4, 9, 5, 8, 40, 90, 400, 900,
			1994, 2444, 3000, 10, 100, 1000, 1365, 2730, 2048, 444, 999};
		no_idle    = 1'b0;
		tx_eager   = 1'b0;
		hold_asked = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_request(directed[i]);
		wait_drained();

		// stall the receiver while requests keep coming, so the queue fills
		hold_asked++;
		tx_eager = 1'b1;
		repeat (HOLD_ITEMS) send_request(pick_value());
		tx_eager = 1'b0;
		wait_drained();

		no_idle = 1'b1;
		repeat (FREE_ITEMS) send_request(pick_value());
		no_idle = 1'b0;

		repeat (RANDOM_ITEMS) send_request(pick_value());
		s_axis_tvalid <= 1'b0;

		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Encoded %0d requests (%0d out of range) into %0d checked symbols,",
			sb.requests_seen, sb.range_errors_seen, sb.symbols_seen);
		$display("with a long receiver hold-off, drained pauses and random idling.");
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
